// ----- rtl/epoch_seconds_to_calendar_top_macros.svh -----
`ifndef EPOCH_SECONDS_TO_CALENDAR_TOP_MACROS_SVH
`define EPOCH_SECONDS_TO_CALENDAR_TOP_MACROS_SVH

// same-cycle property, sampled on clk_i, off during reset
`define ESTC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// antecedent implies consequent in the next cycle
`define ESTC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/estc_pkg.sv -----
package estc_pkg;

  localparam int unsigned InW     = 31;
  localparam int unsigned MulW    = 29;
  localparam int unsigned RecipW  = 30;
  localparam int unsigned ProdW   = MulW + RecipW;
  localparam int unsigned DaysW   = 15;
  localparam int unsigned DataInW = 32;
  localparam int unsigned DataOutW = 48;

  localparam logic [7:0] EpochYear    = 8'd70;
  localparam logic [3:0] LastMonth    = 4'd11;
  localparam logic [3:0] February     = 4'd1;
  localparam logic [2:0] EpochWeekday = 3'd4;

  typedef enum logic [1:0] {
    STG_SEC  = 2'd0,
    STG_MIN  = 2'd1,
    STG_HOUR = 2'd2,
    STG_WDAY = 2'd3
  } stage_e;

  typedef enum logic [2:0] {
    OP_NOP   = 3'd0,
    OP_LOAD  = 3'd1,
    OP_DIV   = 3'd2,
    OP_SAVE  = 3'd3,
    OP_YEAR  = 3'd4,
    OP_MONTH = 3'd5,
    OP_PUB   = 3'd6
  } op_e;

  typedef struct packed {
    op_e    op;
    stage_e stage;
  } cmd_t;

  typedef struct packed {
    logic year_done;
    logic month_done;
    logic out_busy;
  } sts_t;

  function automatic logic [5:0] divisor(stage_e stage);
    logic [5:0] d;
    unique case (stage)
      STG_SEC:  d = 6'd60;
      STG_MIN:  d = 6'd60;
      STG_HOUR: d = 6'd24;
      STG_WDAY: d = 6'd7;
      default:  d = 6'd60;
    endcase
    return d;
  endfunction

  // ceil(2^k / d) for the divisor left after the pre-shift: 15 (k 33), 3 (k 31), 7 (k 32)
  function automatic logic [RecipW-1:0] recip(stage_e stage);
    logic [RecipW-1:0] m;
    unique case (stage)
      STG_HOUR: m = 30'd715827883;
      STG_WDAY: m = 30'd613566757;
      default:  m = 30'd572662307;
    endcase
    return m;
  endfunction

  function automatic logic [4:0] month_len(logic [3:0] mon, logic leap);
    logic [4:0] l;
    unique case (mon)
      4'd0:    l = 5'd31;
      4'd1:    l = leap ? 5'd29 : 5'd28;
      4'd2:    l = 5'd31;
      4'd3:    l = 5'd30;
      4'd4:    l = 5'd31;
      4'd5:    l = 5'd30;
      4'd6:    l = 5'd31;
      4'd7:    l = 5'd31;
      4'd8:    l = 5'd30;
      4'd9:    l = 5'd31;
      4'd10:   l = 5'd30;
      4'd11:   l = 5'd31;
      default: l = 5'd31;
    endcase
    return l;
  endfunction

endpackage

// ----- rtl/estc_ctrl.sv -----
`include "epoch_seconds_to_calendar_top_macros.svh"

module estc_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  estc_pkg::sts_t  sts_i,
  output estc_pkg::cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_SAVE,
    S_YEAR,
    S_MONTH,
    S_DONE
  } state_e;

  state_e                          state_q, state_d;
  estc_pkg::stage_e                stage_q, stage_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    stage_d     = stage_q;
    cmd_o.op    = estc_pkg::OP_NOP;
    cmd_o.stage = stage_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = estc_pkg::OP_LOAD;
          stage_d  = estc_pkg::STG_SEC;
          state_d  = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.op = estc_pkg::OP_DIV;
        state_d  = S_SAVE;
      end
      S_SAVE: begin
        cmd_o.op = estc_pkg::OP_SAVE;
        if (stage_q == estc_pkg::STG_WDAY) begin
          state_d = S_YEAR;
        end else begin
          stage_d = estc_pkg::stage_e'(stage_q + 2'd1);
          state_d = S_DIV;
        end
      end
      S_YEAR: begin
        cmd_o.op = estc_pkg::OP_YEAR;
        if (sts_i.year_done) begin
          state_d = S_MONTH;
        end
      end
      S_MONTH: begin
        cmd_o.op = estc_pkg::OP_MONTH;
        if (sts_i.month_done) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!sts_i.out_busy) begin
          cmd_o.op = estc_pkg::OP_PUB;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      stage_q <= estc_pkg::STG_SEC;
    end else begin
      state_q <= state_d;
      stage_q <= stage_d;
    end
  end

  `ESTC_ASSERT_NEXT(a_accept_starts_div, in_valid_i && in_ready_o, state_q == S_DIV && stage_q == estc_pkg::STG_SEC, "transfer did not start division")
  `ESTC_ASSERT_NEXT(a_div_then_save, state_q == S_DIV, state_q == S_SAVE, "division not followed by save")
  `ESTC_ASSERT(a_pub_only_free, cmd_o.op != estc_pkg::OP_PUB || !sts_i.out_busy, "publish while output occupied")

endmodule

// ----- rtl/estc_dp.sv -----
`include "epoch_seconds_to_calendar_top_macros.svh"

module estc_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  estc_pkg::cmd_t                    cmd_i,
  output estc_pkg::sts_t                    sts_o,
  input  logic [estc_pkg::InW-1:0]          epoch_seconds_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [estc_pkg::DataOutW-1:0]     out_data_o
);

  logic [estc_pkg::InW-1:0]   x_q, x_d;
  logic [estc_pkg::InW-1:0]   quo_q, quo_d;
  logic [estc_pkg::DaysW-1:0] days_q, days_d;
  logic [5:0] sec_q, sec_d, min_q, min_d;
  logic [4:0] hr_q, hr_d;
  logic [2:0] wday_q, wday_d;
  logic [7:0] yr_q, yr_d;
  logic [8:0] yday_q, yday_d;
  logic [3:0] mon_q, mon_d;
  logic [estc_pkg::DataOutW-1:0] out_q, out_d;
  logic       out_valid_q, out_valid_d;

  logic [estc_pkg::MulW-1:0]   mul_a;
  logic [estc_pkg::RecipW-1:0] mul_b;
  logic [estc_pkg::ProdW-1:0]  prod;
  logic [estc_pkg::InW-1:0]    quo;
  logic [7:0]                  rem;
  logic [5:0]                  dv;
  logic                        leap;
  logic [8:0]                  ylen;
  logic [4:0]                  mlen;
  logic [4:0]                  dom;

  assign dv    = estc_pkg::divisor(cmd_i.stage);
  assign mul_b = estc_pkg::recip(cmd_i.stage);
  assign prod  = mul_a * mul_b;
  assign rem   = x_q[7:0] - 8'(quo_q[7:0] * {2'b00, dv});
  assign leap  = (yr_q[1:0] == 2'd0);
  assign ylen  = leap ? 9'd366 : 9'd365;
  assign mlen  = estc_pkg::month_len(mon_q, leap);
  assign dom   = days_q[4:0] + 5'd1;

  assign sts_o.year_done  = (days_q < {6'd0, ylen});
  assign sts_o.month_done = (mon_q == estc_pkg::LastMonth) || (days_q < {10'd0, mlen});
  assign sts_o.out_busy   = out_valid_q && !out_ready_i;

  always_comb begin
    unique case (cmd_i.stage)
      estc_pkg::STG_HOUR: mul_a = {1'b0, x_q[30:3]};
      estc_pkg::STG_WDAY: mul_a = x_q[28:0];
      default:            mul_a = x_q[30:2];
    endcase
  end

  always_comb begin
    unique case (cmd_i.stage)
      estc_pkg::STG_HOUR: quo = {3'd0, prod[58:31]};
      estc_pkg::STG_WDAY: quo = {4'd0, prod[58:32]};
      default:            quo = {5'd0, prod[58:33]};
    endcase
  end

  always_comb begin
    x_d         = x_q;
    quo_d       = quo_q;
    days_d      = days_q;
    sec_d       = sec_q;
    min_d       = min_q;
    hr_d        = hr_q;
    wday_d      = wday_q;
    yr_d        = yr_q;
    yday_d      = yday_q;
    mon_d       = mon_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (cmd_i.op)
      estc_pkg::OP_NOP: begin
      end
      estc_pkg::OP_LOAD: begin
        x_d  = epoch_seconds_i;
        yr_d = estc_pkg::EpochYear;
      end
      estc_pkg::OP_DIV: begin
        quo_d = quo;
      end
      estc_pkg::OP_SAVE: begin
        x_d = quo_q;
        unique case (cmd_i.stage)
          estc_pkg::STG_SEC:  sec_d = rem[5:0];
          estc_pkg::STG_MIN:  min_d = rem[5:0];
          estc_pkg::STG_HOUR: begin
            hr_d   = rem[4:0];
            days_d = quo_q[estc_pkg::DaysW-1:0];
            x_d    = {{(estc_pkg::InW - estc_pkg::DaysW){1'b0}},
                      quo_q[estc_pkg::DaysW-1:0]} + estc_pkg::InW'(estc_pkg::EpochWeekday);
          end
          estc_pkg::STG_WDAY: wday_d = rem[2:0];
          default: begin
          end
        endcase
      end
      estc_pkg::OP_YEAR: begin
        if (sts_o.year_done) begin
          yday_d = days_q[8:0];
          mon_d  = '0;
        end else begin
          days_d = days_q - {6'd0, ylen};
          yr_d   = yr_q + 8'd1;
        end
      end
      estc_pkg::OP_MONTH: begin
        if (!sts_o.month_done) begin
          days_d = days_q - {10'd0, mlen};
          mon_d  = mon_q + 4'd1;
        end
      end
      estc_pkg::OP_PUB: begin
        out_d       = {2'b00, dom, mon_q, yday_q, yr_q, wday_q, hr_q, min_q, sec_q};
        out_valid_d = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    quo_q  <= quo_d;
    days_q <= days_d;
    sec_q  <= sec_d;
    min_q  <= min_d;
    hr_q   <= hr_d;
    wday_q <= wday_d;
    yr_q   <= yr_d;
    yday_q <= yday_d;
    mon_q  <= mon_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `ESTC_ASSERT(a_rem_below_div, cmd_i.op != estc_pkg::OP_SAVE || rem < {2'b00, dv}, "remainder not below divisor")
  `ESTC_ASSERT(a_year_range, cmd_i.op != estc_pkg::OP_YEAR || yr_q <= 8'd138, "year out of range")
  `ESTC_ASSERT(a_valid_from_pub, !$rose(out_valid_q) || $past(cmd_i.op == estc_pkg::OP_PUB), "output valid without publish")

endmodule

// ----- rtl/epoch_seconds_to_calendar_top.sv -----
// From input transfer to output valid, each of the four constant divisions has a
// reciprocal-multiply step and then a remainder step, and the year and then the month
// are found one year and one month per cycle. One item at a time: the next input is
// taken once the result moves to the output register, even while it waits.
// Reset (rst_ni low, asynchronous) empties the output register and idles the control.
module epoch_seconds_to_calendar_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // [30:0] epoch_seconds, [31] zero
  input  logic [estc_pkg::DataInW-1:0]      s_axis_tdata_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // [5:0] second, [11:6] minute, [16:12] hour, [19:17] weekday,
  // [27:20] years_since_1900, [36:28] day_of_year, [40:37] month,
  // [45:41] day_of_month, [47:46] zero
  output logic [estc_pkg::DataOutW-1:0]     m_axis_tdata_o
);

  estc_pkg::cmd_t cmd;
  estc_pkg::sts_t sts;

  estc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  estc_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .epoch_seconds_i (s_axis_tdata_i[estc_pkg::InW-1:0]),
    .out_valid_o     (m_axis_tvalid_o),
    .out_ready_i     (m_axis_tready_i),
    .out_data_o      (m_axis_tdata_o)
  );

endmodule
